/* sv/chi_pkg.sv */
`timescale 1ns / 1ps
// chi_pkg: shared types and constants for the cuckoo hash insert unit
// field widths, result codes, slot layout, controller states, command/status structs
// no dependencies

package chi_pkg;

    // fixed field widths
    localparam int KEY_W  = 31;
    localparam int KICK_W = 8;
    localparam int ST_W   = 2;

    // defaults
    localparam int TABLE_SIZE_DEF = 11;
    localparam logic [KICK_W-1:0] MAX_KICKS_RST = 8'd16;

    // result codes
    typedef enum logic [ST_W-1:0] {
        ST_PLACED  = 2'd0,
        ST_PRESENT = 2'd1,
        ST_DROPPED = 2'd2
    } t_status;

    // one table slot
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } t_slot;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_READ,
        S_CHECK,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    clr;
        logic    start;
        logic    mul1;
        logic    mul2;
        logic    mul3;
        logic    rd;
        logic    evict;
        logic    place;
        logic    set_st;
        t_status st;
        logic    load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic limit_hit;
        logic hit;
        logic dst_valid;
        logic cnt_zero;
        logic out_free;
    } t_sts;

endpackage

/* sv/chi_key_if.sv */
`timescale 1ns / 1ps
// chi_key_if: input channel carrying one key per item
// depends on chi_pkg

interface chi_key_if;
    logic                     valid;
    logic                     ready;
    logic [chi_pkg::KEY_W-1:0] key;

    modport source (output valid, output key, input ready);
    modport sink   (input valid, input key, output ready);
endinterface

/* sv/chi_res_if.sv */
`timescale 1ns / 1ps
// chi_res_if: result channel, one result item per inserted key
// depends on chi_pkg

interface chi_res_if;
    logic                      valid;
    logic                      ready;
    logic [chi_pkg::ST_W-1:0]   status;
    logic [chi_pkg::KEY_W-1:0]  dropped_key;
    logic [chi_pkg::KICK_W-1:0] kicks;

    modport source (output valid, output status, output dropped_key, output kicks,
                    input ready);
    modport sink   (input valid, input status, input dropped_key, input kicks,
                    output ready);
endinterface

/* sv/chi_ctrl.sv */
`timescale 1ns / 1ps
// chi_ctrl: state machine sequencing clear pass, hashing, table lookup and eviction
// depends on chi_pkg

module chi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  chi_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output chi_pkg::t_cmd o_cmd
);

    chi_pkg::t_state r_state;
    chi_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= chi_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            chi_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = chi_pkg::S_IDLE;
            end
            chi_pkg::S_IDLE: begin
                if (i_in_valid) n_state = chi_pkg::S_HASH1;
            end
            chi_pkg::S_HASH1: begin
                n_state = i_sts.limit_hit ? chi_pkg::S_EMIT : chi_pkg::S_HASH2;
            end
            chi_pkg::S_HASH2: n_state = chi_pkg::S_HASH3;
            chi_pkg::S_HASH3: n_state = chi_pkg::S_READ;
            chi_pkg::S_READ:  n_state = chi_pkg::S_CHECK;
            chi_pkg::S_CHECK: begin
                if (!i_sts.hit && i_sts.dst_valid) n_state = chi_pkg::S_HASH1;
                else                               n_state = chi_pkg::S_EMIT;
            end
            chi_pkg::S_EMIT: begin
                if (i_sts.out_free) n_state = chi_pkg::S_IDLE;
            end
            default: n_state = chi_pkg::S_CLEAR;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.st   = chi_pkg::ST_PLACED;
        o_in_ready = 1'b0;
        case (r_state)
            chi_pkg::S_CLEAR: o_cmd.clr = 1'b1;
            chi_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            chi_pkg::S_HASH1: begin
                if (i_sts.limit_hit) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = chi_pkg::ST_DROPPED;
                end else begin
                    o_cmd.mul1 = 1'b1;
                end
            end
            chi_pkg::S_HASH2: o_cmd.mul2 = 1'b1;
            chi_pkg::S_HASH3: o_cmd.mul3 = 1'b1;
            chi_pkg::S_READ:  o_cmd.rd   = 1'b1;
            chi_pkg::S_CHECK: begin
                if (i_sts.hit) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = i_sts.cnt_zero ? chi_pkg::ST_PRESENT : chi_pkg::ST_PLACED;
                end else if (i_sts.dst_valid) begin
                    o_cmd.evict = 1'b1;
                end else begin
                    o_cmd.place  = 1'b1;
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = chi_pkg::ST_PLACED;
                end
            end
            chi_pkg::S_EMIT: o_cmd.load_out = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* sv/chi_dp.sv */
`timescale 1ns / 1ps
// chi_dp: key in hand, hash arithmetic, the two slot tables and the result register
// depends on chi_pkg

module chi_dp #(
    parameter int TABLE_SIZE = chi_pkg::TABLE_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  chi_pkg::t_cmd              i_cmd,
    input  logic [chi_pkg::KEY_W-1:0]  i_key,
    input  logic                       i_out_ready,
    input  logic                       i_cfg_we,
    input  logic [chi_pkg::KICK_W-1:0] i_cfg_data,
    output chi_pkg::t_sts              o_sts,
    output logic                       o_out_valid,
    output logic [chi_pkg::ST_W-1:0]   o_status,
    output logic [chi_pkg::KEY_W-1:0]  o_dropped_key,
    output logic [chi_pkg::KICK_W-1:0] o_kicks
);

    localparam int KEY_W  = chi_pkg::KEY_W;
    localparam int KICK_W = chi_pkg::KICK_W;
    localparam int IDX_W  = $clog2(TABLE_SIZE);
    // reciprocal: floor(x / TABLE_SIZE) == (x * RECIP) >> SHIFT for any x below 2^KEY_W
    localparam int SHIFT  = KEY_W + IDX_W;
    localparam int RECIP_W = KEY_W + 2;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
    localparam int P1_W  = KEY_W + RECIP_W;
    localparam int Q1_W  = KEY_W - IDX_W + 1;
    localparam int P2_W  = Q1_W + RECIP_W;
    localparam int Q2_W  = Q1_W - IDX_W + 1;
    localparam logic [KEY_W-1:0] SIZE_K   = KEY_W'(TABLE_SIZE);
    localparam logic [Q1_W-1:0]  SIZE_Q   = Q1_W'(TABLE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    chi_pkg::t_slot r_mem0 [TABLE_SIZE];
    chi_pkg::t_slot r_mem1 [TABLE_SIZE];
    chi_pkg::t_slot r_rd0;
    chi_pkg::t_slot r_rd1;

    logic [KEY_W-1:0]  r_hand;
    logic              r_side;
    logic [KICK_W-1:0] r_cnt;
    logic [KICK_W-1:0] r_max_kicks;
    logic [IDX_W-1:0]  r_clr_idx;
    logic [P1_W-1:0]   r_prod1;
    logic [P2_W-1:0]   r_prod2;
    logic [Q1_W-1:0]   r_q1;
    logic [IDX_W-1:0]  r_p0;
    logic [IDX_W-1:0]  r_p1;
    chi_pkg::t_status  r_res_st;

    logic              r_out_valid;
    logic [chi_pkg::ST_W-1:0] r_out_status;
    logic [KEY_W-1:0]  r_out_drop;
    logic [KICK_W-1:0] r_out_kicks;

    logic [Q1_W-1:0]   q1;
    logic [Q2_W-1:0]   q2;
    logic [P1_W-1:0]   n_prod1;
    logic [P2_W-1:0]   n_prod2;
    logic [IDX_W-1:0]  n_p0;
    logic [IDX_W-1:0]  n_p1;
    chi_pkg::t_slot    wr_slot;
    logic              wr0;
    logic              wr1;

    // hash arithmetic: quotient by reciprocal, remainder by multiply-subtract
    always_comb begin
        n_prod1 = P1_W'(r_hand) * P1_W'(RECIP);
        q1      = r_prod1[SHIFT +: Q1_W];
        n_prod2 = P2_W'(q1) * P2_W'(RECIP);
        n_p0    = IDX_W'(r_hand - KEY_W'(KEY_W'(q1) * SIZE_K));
        q2      = r_prod2[SHIFT +: Q2_W];
        n_p1    = IDX_W'(r_q1 - Q1_W'(Q1_W'(q2) * SIZE_Q));
    end

    // config register, clear counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_kicks <= chi_pkg::MAX_KICKS_RST;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_max_kicks <= i_cfg_data;
            if (i_cmd.clr) r_clr_idx <= r_clr_idx + IDX_W'(1);
            if (i_cmd.load_out)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // key in hand, eviction count and hash pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_hand <= i_key;
            r_side <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.evict) begin
            r_hand <= r_side ? r_rd1.key : r_rd0.key;
            r_side <= ~r_side;
            r_cnt  <= r_cnt + KICK_W'(1);
        end
        if (i_cmd.mul1) r_prod1 <= n_prod1;
        if (i_cmd.mul2) begin
            r_q1    <= q1;
            r_prod2 <= n_prod2;
            r_p0    <= n_p0;
        end
        if (i_cmd.mul3) r_p1 <= n_p1;
        if (i_cmd.set_st) r_res_st <= i_cmd.st;
    end

    // table writes: clear pass, eviction or placement
    always_comb begin
        wr_slot.valid = 1'b1;
        wr_slot.key   = r_hand;
        wr0 = (i_cmd.evict || i_cmd.place) && !r_side;
        wr1 = (i_cmd.evict || i_cmd.place) && r_side;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem0[r_clr_idx] <= '0;
            r_mem1[r_clr_idx] <= '0;
        end else begin
            if (wr0) r_mem0[r_p0] <= wr_slot;
            if (wr1) r_mem1[r_p1] <= wr_slot;
        end
    end

    // registered table reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd0 <= r_mem0[r_p0];
            r_rd1 <= r_mem1[r_p1];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= r_res_st;
            r_out_drop   <= (r_res_st == chi_pkg::ST_DROPPED) ? r_hand : '0;
            r_out_kicks  <= r_cnt;
        end
    end

    // status to controller
    always_comb begin
        o_sts.clr_last  = (r_clr_idx == LAST_IDX);
        o_sts.limit_hit = (r_cnt == r_max_kicks);
        o_sts.hit       = (r_rd0.valid && (r_rd0.key == r_hand)) ||
                          (r_rd1.valid && (r_rd1.key == r_hand));
        o_sts.dst_valid = r_side ? r_rd1.valid : r_rd0.valid;
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_dropped_key = r_out_drop;
    assign o_kicks       = r_out_kicks;

endmodule

/* sv/cuckoo_hash_insert_unit.sv */
`timescale 1ns / 1ps
// cuckoo_hash_insert_unit: two-table cuckoo hash insert, top level
// depends on chi_pkg, chi_key_if, chi_res_if, chi_ctrl, chi_dp
//
// Usage:
//   i_key carries one key per item; o_res returns one item per key with the
//   status (placed, already present, dropped), the dropped key and the
//   eviction count. i_cfg_we / i_cfg_data write max_kicks; the user must do
//   so only while idle, since the block itself does not enforce it. Each
//   step of the insert (hash the key in hand, read both tables, then place,
//   stop or evict) runs through HASH1, HASH2, HASH3, READ and CHECK: the
//   hash uses two reciprocal multiplies and the table read is registered.
//   An insert that reaches the eviction limit is dropped in HASH1, before
//   the key in hand is hashed. The next key can be accepted in the cycle
//   after the result is loaded; no key is taken while an insert is in work.
//   After reset both tables are cleared one slot a cycle, slots 0 to
//   TABLE_SIZE-1, during which no key is accepted; max_kicks resets to 16.
//   The result sits in an output register: a new key is taken while it waits.
//   If the receiver stalls with a result still pending, the next finished
//   result holds until the register frees.

module cuckoo_hash_insert_unit #(
    parameter int TABLE_SIZE = chi_pkg::TABLE_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    chi_key_if.sink                    i_key,
    chi_res_if.source                  o_res,
    input  logic                       i_cfg_we,
    input  logic [chi_pkg::KICK_W-1:0] i_cfg_data
);

    chi_pkg::t_cmd cmd;
    chi_pkg::t_sts sts;

    // controller
    chi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_key.valid),
        .i_sts      (sts),
        .o_in_ready (i_key.ready),
        .o_cmd      (cmd)
    );

    // datapath
    chi_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_key         (i_key.key),
        .i_out_ready   (o_res.ready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_sts         (sts),
        .o_out_valid   (o_res.valid),
        .o_status      (o_res.status),
        .o_dropped_key (o_res.dropped_key),
        .o_kicks       (o_res.kicks)
    );

    // table writes never collide
    a_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr, cmd.evict, cmd.place}))
        else $error("conflicting table writes");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_res.valid || o_res.ready))
        else $error("result register overwritten");

    // no table activity while a key is being accepted
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_key.ready |-> !(cmd.evict || cmd.place || cmd.clr || cmd.rd))
        else $error("table activity while idle");

    // an eviction only follows a miss on an occupied slot
    a_evict_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.evict |-> (!sts.hit && sts.dst_valid && !sts.limit_hit))
        else $error("eviction without cause");

    // a key in work blocks the next one
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> !i_key.ready)
        else $error("input ready while an insert is in work");

endmodule

/* dv/cuckoo_hash_insert_unit_tb.sv */
`timescale 1ns / 1ps
// cuckoo_hash_insert_unit_tb: self-checking bench for the two-table cuckoo insert unit
// predicts status, dropped key and eviction count per key from a local copy of both tables
// depends on chi_pkg, chi_key_if, chi_res_if and cuckoo_hash_insert_unit

module cuckoo_hash_insert_unit_tb;

    localparam int          KEY_W        = chi_pkg::KEY_W;
    localparam int          KICK_W       = chi_pkg::KICK_W;
    localparam int unsigned TBL          = chi_pkg::TABLE_SIZE_DEF;
    localparam int          STALL_LIMIT  = 8000;
    localparam int          SETTLE_CYC   = 12;
    localparam int          LONG_HOLD    = 400;
    localparam int          RECENT_DEPTH = 32;

    typedef struct packed {
        chi_pkg::t_status    status;
        logic [KEY_W-1:0]    dropped_key;
        logic [KICK_W-1:0]   kicks;
    } t_insert_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [KICK_W-1:0]  i_cfg_data;

    chi_key_if key_ch ();
    chi_res_if res_ch ();

    // predictor state: both tables and the eviction limit
    chi_pkg::t_slot    first_slots  [TBL];
    chi_pkg::t_slot    second_slots [TBL];
    logic [KICK_W-1:0] kick_limit;

    logic [KEY_W-1:0]  pending_keys [$];
    t_insert_result    expected_results [$];
    logic [KEY_W-1:0]  recent_keys [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_requests;
    int holds_started;
    int hold_left;
    int mismatch_count;
    int stall_cycles;

    cuckoo_hash_insert_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (key_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // insert one key into the local tables, return what the block should report
    function automatic t_insert_result cuckoo_insert(input logic [KEY_W-1:0] key);
        t_insert_result    r;
        logic [KEY_W-1:0]  hand;
        logic [KEY_W-1:0]  bumped;
        bit                side;
        int unsigned       p0;
        int unsigned       p1;
        int unsigned       kicks;
        r.status      = chi_pkg::ST_PLACED;
        r.dropped_key = '0;
        hand  = key;
        side  = 1'b0;
        kicks = 0;
        forever begin
            // limit is tested ahead of the presence check
            if (kicks == kick_limit) begin
                r.status      = chi_pkg::ST_DROPPED;
                r.dropped_key = hand;
                break;
            end
            p0 = hand % TBL;
            p1 = (hand / TBL) % TBL;
            if ((first_slots[p0].valid && first_slots[p0].key == hand) ||
                (second_slots[p1].valid && second_slots[p1].key == hand)) begin
                r.status = (kicks == 0) ? chi_pkg::ST_PRESENT : chi_pkg::ST_PLACED;
                break;
            end
            if (!side) begin
                if (!first_slots[p0].valid) begin
                    first_slots[p0] = '{valid: 1'b1, key: hand};
                    break;
                end
                bumped = first_slots[p0].key;
                first_slots[p0].key = hand;
            end else begin
                if (!second_slots[p1].valid) begin
                    second_slots[p1] = '{valid: 1'b1, key: hand};
                    break;
                end
                bumped = second_slots[p1].key;
                second_slots[p1].key = hand;
            end
            hand  = bumped;
            side  = !side;
            kicks = kicks + 1;
        end
        r.kicks = kicks[KICK_W-1:0];
        return r;
    endfunction

    // mix of repeated keys, small colliding keys and full-range keys
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] k;
        int unsigned      sel;
        sel = $urandom_range(99);
        if (sel < 35 && recent_keys.size() > 0)
            k = recent_keys[$urandom_range(recent_keys.size() - 1)];
        else if (sel < 60)
            k = KEY_W'($urandom_range(400));
        else
            k = KEY_W'($urandom());
        recent_keys.push_back(k);
        if (recent_keys.size() > RECENT_DEPTH)
            void'(recent_keys.pop_front());
        return k;
    endfunction

    // key driver, predicts at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_ch.valid <= 1'b0;
            key_ch.key   <= '0;
        end else begin
            if (key_ch.valid && key_ch.ready)
                expected_results.push_back(cuckoo_insert(key_ch.key));
            if (!key_ch.valid || key_ch.ready) begin
                if (pending_keys.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    key_ch.valid <= 1'b1;
                    key_ch.key   <= pending_keys.pop_front();
                end else begin
                    key_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with ready throttling and long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready  <= 1'b0;
            hold_left     <= 0;
            holds_started <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("[%0t] unexpected result item: status %0d key %0h kicks %0d",
                                 $realtime, res_ch.status, res_ch.dropped_key, res_ch.kicks);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    t_insert_result exp_r;
                    exp_r = expected_results.pop_front();
                    if (exp_r.status != res_ch.status || exp_r.dropped_key != res_ch.dropped_key ||
                        exp_r.kicks != res_ch.kicks) begin
                        if (mismatch_count < 10)
                            $display("[%0t] exp status/key/kicks %0d/%0h/%0d, got %0d/%0h/%0d",
                                     $realtime,
                                     exp_r.status, exp_r.dropped_key, exp_r.kicks,
                                     res_ch.status, res_ch.dropped_key, res_ch.kicks);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (holds_started != hold_requests) begin
                holds_started <= hold_requests;
                hold_left     <= LONG_HOLD;
                res_ch.ready  <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // wait until every key is taken and every result has come back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_keys.size() != 0 || key_ch.valid || expected_results.size() != 0);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // register write, only while the block is idle
    task automatic set_max_kicks(input logic [KICK_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        kick_limit  = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n, input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) pending_keys.push_back(pick_key());
        wait_drained();
    endtask

    // stimulus
    initial begin
        logic [KEY_W-1:0] seed_keys [14] = '{
            31'd0, 31'h7FFF_FFFF, 31'd0, 31'd11, 31'd0, 31'd121, 31'd242,
            31'd1, 31'd12, 31'd23, 31'h7FFF_FFFE, 31'h5555_5555, 31'h2AAA_AAAA, 31'd5
        };
        logic [KEY_W-1:0] zero_limit_keys [4] = '{31'd0, 31'h7FFF_FFFF, 31'd999, 31'd5};

        key_ch.valid   = 1'b0;
        key_ch.key     = '0;
        res_ch.ready   = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        kick_limit     = chi_pkg::MAX_KICKS_RST;
        foreach (first_slots[i]) begin
            first_slots[i]  = '0;
            second_slots[i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, repeats and collisions on slot zero
        foreach (seed_keys[i]) pending_keys.push_back(seed_keys[i]);
        wait_drained();

        // zero limit drops every key, present ones too
        set_max_kicks(8'd0);
        foreach (zero_limit_keys[i]) pending_keys.push_back(zero_limit_keys[i]);
        wait_drained();

        set_max_kicks(8'd1);
        run_random(400, 48, 0);

        // largest limit, few items since chains run long
        set_max_kicks(8'd255);
        run_random(40, 19, 19);

        // receiver holds off while the sender keeps offering
        set_max_kicks(8'd3);
        hold_requests = hold_requests + 1;
        run_random(400, 0, 48);

        // sender pauses mid-phase until all results are back
        set_max_kicks(8'd16);
        run_random(200, 0, 0);
        run_random(200, 0, 0);

        set_max_kicks(8'd8);
        run_random(400, 19, 19);

        set_max_kicks(8'd200);
        run_random(30, 48, 48);

        set_max_kicks(8'($urandom_range(2, 32)));
        run_random(350, 48, 48);

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
sv/chi_pkg.sv
sv/chi_key_if.sv
sv/chi_res_if.sv
sv/chi_ctrl.sv
sv/chi_dp.sv
sv/cuckoo_hash_insert_unit.sv
dv/cuckoo_hash_insert_unit_tb.sv
